// ===== sv/mgmt_pkg.sv =====
// Shared types for the multicast group member table.
// This file holds the controller/datapath command and status structs, the operation codes
// and the fixed field widths. It has no dependencies.
package mgmt_pkg;

   // Width of a group address and of a member bitmap.
   localparam int ADDR_W  = 32;
   localparam int MASK_W  = 32;
   localparam int IFACE_W = 5;
   localparam int FUNC_W  = 2;

   // Operation codes. The spare code behaves as a lookup.
   localparam logic [FUNC_W-1:0] FUNC_JOIN   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LEAVE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_SPARE  = 2'd3;

   // Commands from the controller to the datapath, one per processing step.
   typedef struct packed {
      logic load;
      logic match;
      logic encode;
      logic read;
      logic update;
   } mgmt_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic out_free;
   } mgmt_status_type;

endpackage

// ===== sv/multicast_group_member_table_unit.sv =====
// Multicast group member table, top level: a sequencing controller and a table datapath.
// This file depends on mgmt_pkg, mgmt_ctrl and mgmt_datapath.
//
// Each transaction is a join, leave or lookup of one group address and gives exactly one
// result: whether the group had a row, the group's interface bitmap afterwards (zero when it
// has no row) and a flag for a join dropped because every row was taken. From acceptance, a
// transaction passes through a parallel address compare over all rows, a lowest row encode,
// a read of the bitmap memory, and the update that writes the row and loads the result
// register. A new transaction is accepted in the update cycle of the previous one, so a new
// transaction is not taken before the previous one reaches its update step; a stalled
// result holds the block in its update step. Row valid bits are cleared by reset directly, so
// the table needs no clearing pass and accepts transactions right after reset.
module multicast_group_member_table_unit #(
   parameter int NUM_ROWS   = 32,
   parameter int NUM_IFACES = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [mgmt_pkg::FUNC_W-1:0]  req_func,
   input  logic [mgmt_pkg::ADDR_W-1:0]  req_group_addr,
   input  logic [mgmt_pkg::IFACE_W-1:0] req_iface,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit,
   output logic [mgmt_pkg::MASK_W-1:0]  rsp_member_mask,
   output logic                         rsp_table_full
);

   mgmt_pkg::mgmt_cmd_type    cmd;
   mgmt_pkg::mgmt_status_type status;

   // Step sequencing and input handshake.
   mgmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Table storage, match logic and result register.
   mgmt_datapath #(
      .NUM_ROWS   (NUM_ROWS),
      .NUM_IFACES (NUM_IFACES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_func),
      .req_group_addr  (req_group_addr),
      .req_iface       (req_iface),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_member_mask (rsp_member_mask),
      .rsp_table_full  (rsp_table_full)
   );

endmodule

// ===== sv/mgmt_ctrl.sv =====
// Sequencing controller for the multicast group member table.
// This file depends on mgmt_pkg for the command and status structs.
module mgmt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  mgmt_pkg::mgmt_status_type status,
   output mgmt_pkg::mgmt_cmd_type   cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MATCH,
      S_ENCODE,
      S_READ,
      S_UPDATE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      take_req;

   // A new transaction enters when idle, or in the last step once its result can be stored.
   // Nothing enters while reset is held.
   always_comb begin
      req_stall = reset || !((state_ff == S_IDLE) ||
                             ((state_ff == S_UPDATE) && status.out_free));
      take_req  = req_valid && !req_stall;
   end

   // Commands follow the current step.
   always_comb begin
      cmd.load   = take_req;
      cmd.match  = (state_ff == S_MATCH);
      cmd.encode = (state_ff == S_ENCODE);
      cmd.read   = (state_ff == S_READ);
      cmd.update = (state_ff == S_UPDATE) && status.out_free;
   end

   // Next step of the sequence.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (take_req) state_in = S_MATCH;
         end
         S_MATCH:  state_in = S_ENCODE;
         S_ENCODE: state_in = S_READ;
         S_READ:   state_in = S_UPDATE;
         S_UPDATE: begin
            if (status.out_free) state_in = take_req ? S_MATCH : S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The table is only updated while the result register can take the result.
   a_update_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> status.out_free)
      else $error("update issued while result register is occupied");

   // A transaction is only taken when no earlier one is still in the middle steps.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.match)
      else $error("accepted transaction did not start matching");

   // Every match step leads to a read step, with the encode step between them.
   a_sequence: assert property (@(posedge clock) disable iff (reset)
      cmd.match |=> ##1 cmd.read)
      else $error("match step not followed by read step");

endmodule

// ===== sv/mgmt_datapath.sv =====
// Datapath of the multicast group member table: row storage, parallel match, encoders and update.
// This file depends on mgmt_pkg for widths, operation codes and the command and status structs.
module mgmt_datapath #(
   parameter int NUM_ROWS   = 32,
   parameter int NUM_IFACES = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mgmt_pkg::mgmt_cmd_type             cmd,
   output mgmt_pkg::mgmt_status_type          status,
   input  logic [mgmt_pkg::FUNC_W-1:0]        req_func,
   input  logic [mgmt_pkg::ADDR_W-1:0]        req_group_addr,
   input  logic [mgmt_pkg::IFACE_W-1:0]       req_iface,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_hit,
   output logic [mgmt_pkg::MASK_W-1:0]        rsp_member_mask,
   output logic                               rsp_table_full
);

   localparam int IDX_W = $clog2(NUM_ROWS);
   localparam logic [6:0] IFACE_LIMIT = 7'(NUM_IFACES);

   // Captured transaction.
   logic [mgmt_pkg::FUNC_W-1:0]  func_ff;
   logic [mgmt_pkg::ADDR_W-1:0]  addr_ff;
   logic [mgmt_pkg::IFACE_W-1:0] iface_ff;

   // Row storage: valid bits and group addresses in flops, bitmaps in a memory.
   logic [NUM_ROWS-1:0]         valid_ff;
   logic [mgmt_pkg::ADDR_W-1:0] group_ff [NUM_ROWS];
   logic [mgmt_pkg::MASK_W-1:0] members_mem [NUM_ROWS];

   // Match step results.
   logic [NUM_ROWS-1:0] match_ff;
   logic [NUM_ROWS-1:0] free_ff;

   // Encode step results.
   logic             hit_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   logic             free_any_ff;
   logic [IDX_W-1:0] free_idx_ff;

   // Bitmap read for the matching row.
   logic [mgmt_pkg::MASK_W-1:0] rd_ff;

   // Result register.
   logic                        rsp_valid_ff;
   logic                        rsp_hit_ff;
   logic [mgmt_pkg::MASK_W-1:0] rsp_mask_ff;
   logic                        rsp_full_ff;
   logic                        rsp_valid_in;

   // Update step decode.
   logic                        ifc_ok;
   logic                        is_join;
   logic                        is_leave;
   logic [mgmt_pkg::MASK_W-1:0] iface_bit;
   logic [mgmt_pkg::MASK_W-1:0] joined_mask;
   logic [mgmt_pkg::MASK_W-1:0] left_mask;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_idx;
   logic [mgmt_pkg::MASK_W-1:0] wr_data;
   logic                        set_valid;
   logic                        clr_valid;
   logic [mgmt_pkg::MASK_W-1:0] out_mask;
   logic                        out_full;

   // Index of the lowest set bit of a row vector.
   function automatic logic [IDX_W-1:0] lowest_set(input logic [NUM_ROWS-1:0] vec);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int r = NUM_ROWS - 1; r >= 0; r--) begin
         if (vec[r]) idx = IDX_W'(r);
      end
      return idx;
   endfunction

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // Capture the accepted transaction.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         addr_ff  <= req_group_addr;
         iface_ff <= req_iface;
      end
   end

   // Compare the address against every row in parallel.
   always_ff @(posedge clock) begin
      if (cmd.match) begin
         for (int r = 0; r < NUM_ROWS; r++) begin
            match_ff[r] <= valid_ff[r] && (group_ff[r] == addr_ff);
            free_ff[r]  <= !valid_ff[r];
         end
      end
   end

   // Reduce the match and free vectors to row numbers.
   always_ff @(posedge clock) begin
      if (cmd.encode) begin
         hit_ff      <= |match_ff;
         hit_idx_ff  <= lowest_set(match_ff);
         free_any_ff <= |free_ff;
         free_idx_ff <= lowest_set(free_ff);
      end
   end

   // Work out the row change and the result of the current transaction.
   always_comb begin
      ifc_ok      = ({2'b00, iface_ff} < IFACE_LIMIT);
      is_join     = (func_ff == mgmt_pkg::FUNC_JOIN) && ifc_ok;
      is_leave    = (func_ff == mgmt_pkg::FUNC_LEAVE) && ifc_ok;
      iface_bit   = mgmt_pkg::MASK_W'(1) << iface_ff;
      joined_mask = rd_ff | iface_bit;
      left_mask   = rd_ff & ~iface_bit;
      wr_en       = 1'b0;
      wr_idx      = hit_idx_ff;
      wr_data     = joined_mask;
      set_valid   = 1'b0;
      clr_valid   = 1'b0;
      out_full    = 1'b0;
      out_mask    = hit_ff ? rd_ff : '0;
      if (is_join) begin
         if (hit_ff) begin
            wr_en    = 1'b1;
            out_mask = joined_mask;
         end else if (free_any_ff) begin
            wr_en     = 1'b1;
            wr_idx    = free_idx_ff;
            wr_data   = iface_bit;
            set_valid = 1'b1;
            out_mask  = iface_bit;
         end else begin
            out_full = 1'b1;
         end
      end else if (is_leave && hit_ff) begin
         wr_en     = 1'b1;
         wr_data   = left_mask;
         clr_valid = (left_mask == '0);
         out_mask  = left_mask;
      end
   end

   // Bitmap memory: one write and one registered read.
   always_ff @(posedge clock) begin
      if (cmd.update && wr_en) members_mem[wr_idx] <= wr_data;
      if (cmd.read) rd_ff <= members_mem[hit_idx_ff];
   end

   // Group address of a newly taken row.
   always_ff @(posedge clock) begin
      if (cmd.update && set_valid) group_ff[free_idx_ff] <= addr_ff;
   end

   // Row valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.update) begin
         if (set_valid) valid_ff[free_idx_ff] <= 1'b1;
         if (clr_valid) valid_ff[hit_idx_ff]  <= 1'b0;
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.update) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_hit_ff  <= hit_ff;
         rsp_mask_ff <= out_mask;
         rsp_full_ff <= out_full;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_member_mask = rsp_mask_ff;
   assign rsp_table_full  = rsp_full_ff;

   // A group never occupies two rows.
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      cmd.encode |-> $onehot0(match_ff))
      else $error("group address found in more than one row");

   // A join is only reported as dropped when every row is taken.
   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && out_full) |-> (&valid_ff))
      else $error("join dropped while a row was free");

   // A join of a new group leaves its row valid.
   a_new_row_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && set_valid) |=> valid_ff[$past(free_idx_ff)])
      else $error("newly joined row is not valid");

endmodule

// ===== verif/tb_top.sv =====
// Testbench for multicast_group_member_table_unit: joins, leaves and lookups checked
// against a table model kept in the testbench. Depends on mgmt_pkg and the RTL top level.
// Self-contained: stimulus and expected results are both built at run time.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TBL_ROWS   = 32;
   localparam int TBL_IFACES = 32;
   localparam int POOL_SIZE  = 48;
   localparam int RAND_ITEMS = 900;
   localparam int MAX_REPORT = 10;

   // Operation codes; the spare code behaves as a lookup.
   typedef enum logic [mgmt_pkg::FUNC_W-1:0] {
      OP_JOIN   = mgmt_pkg::FUNC_JOIN,
      OP_LEAVE  = mgmt_pkg::FUNC_LEAVE,
      OP_LOOKUP = mgmt_pkg::FUNC_LOOKUP,
      OP_SPARE  = mgmt_pkg::FUNC_SPARE
   } func_code_type;

   // Random segment flavors: grow the table, shrink it, or a mix.
   typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIX} segment_type;

   typedef struct {
      func_code_type                func;
      logic [mgmt_pkg::ADDR_W-1:0]  group_addr;
      logic [mgmt_pkg::IFACE_W-1:0] iface;
      int unsigned                  phase;
      bit                           drain_first;
   } group_op_type;

   typedef struct packed {
      logic                        hit;
      logic [mgmt_pkg::MASK_W-1:0] member_mask;
      logic                        table_full;
   } member_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [mgmt_pkg::FUNC_W-1:0]  req_func = '0;
   logic [mgmt_pkg::ADDR_W-1:0]  req_group_addr = '0;
   logic [mgmt_pkg::IFACE_W-1:0] req_iface = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_hit;
   logic [mgmt_pkg::MASK_W-1:0]  rsp_member_mask;
   logic                         rsp_table_full;

   // Idle percentages per phase for the sender and for the receiver.
   int unsigned send_idle_pct [3] = '{15, 88, 0};
   int unsigned rsp_idle_pct  [3] = '{88, 15, 0};

   group_op_type       group_op_q [$];
   member_result_type  member_result_q [$];

   // Table model.
   bit                          grp_valid   [TBL_ROWS];
   logic [mgmt_pkg::ADDR_W-1:0] grp_addr    [TBL_ROWS];
   logic [mgmt_pkg::MASK_W-1:0] grp_members [TBL_ROWS];

   bit          req_accepted = 1'b0;
   int unsigned rsp_phase = 0;
   int unsigned mismatch_count = 0;
   int unsigned result_count = 0;
   int unsigned join_count = 0;
   int unsigned leave_count = 0;
   int unsigned lookup_count = 0;
   int unsigned hit_count = 0;
   int unsigned full_count = 0;
   int unsigned row_freed_count = 0;

   multicast_group_member_table_unit #(
      .NUM_ROWS   (TBL_ROWS),
      .NUM_IFACES (TBL_IFACES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_group_addr  (req_group_addr),
      .req_iface       (req_iface),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_member_mask (rsp_member_mask),
      .rsp_table_full  (rsp_table_full)
   );

   always #2ns clock = ~clock;

   // Applies one operation to the table model and returns the result it must produce.
   function automatic member_result_type apply_group_op(group_op_type op);
      member_result_type           res;
      int                          row;
      int                          r;
      bit                          was_hit;
      bit                          iface_ok;
      logic [mgmt_pkg::MASK_W-1:0] bit_sel;
      row = -1;
      for (r = 0; r < TBL_ROWS; r++) begin
         if (row < 0 && grp_valid[r] && grp_addr[r] == op.group_addr) begin
            row = r;
         end
      end
      was_hit  = (row >= 0);
      iface_ok = (op.iface < TBL_IFACES) && (op.iface < mgmt_pkg::MASK_W);
      bit_sel  = mgmt_pkg::MASK_W'(1) << op.iface;
      res.table_full = 1'b0;
      if (op.func == OP_JOIN && iface_ok) begin
         if (!was_hit) begin
            // A new group takes the lowest free row.
            for (r = 0; r < TBL_ROWS; r++) begin
               if (row < 0 && !grp_valid[r]) begin
                  row = r;
               end
            end
            if (row >= 0) begin
               grp_valid[row]   = 1'b1;
               grp_addr[row]    = op.group_addr;
               grp_members[row] = '0;
            end else begin
               res.table_full = 1'b1;
            end
         end
         if (row >= 0) begin
            grp_members[row] |= bit_sel;
         end
      end else if (op.func == OP_LEAVE && iface_ok && was_hit) begin
         // The row is freed once its last member leaves.
         grp_members[row] &= ~bit_sel;
         if (grp_members[row] == '0) begin
            grp_valid[row] = 1'b0;
            row_freed_count++;
         end
      end
      res.hit         = was_hit;
      res.member_mask = (row >= 0 && grp_valid[row]) ? grp_members[row] : '0;
      return res;
   endfunction

   task automatic add_op(func_code_type func, logic [mgmt_pkg::ADDR_W-1:0] addr,
                         logic [mgmt_pkg::IFACE_W-1:0] iface,
                         int unsigned phase, bit drain_first);
      group_op_type op;
      op.func        = func;
      op.group_addr  = addr;
      op.iface       = iface;
      op.phase       = phase;
      op.drain_first = drain_first;
      group_op_q.push_back(op);
   endtask

   // Request driver: holds a stalled transaction, otherwise sends or idles at random.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_accepted) begin
         req_valid <= 1'b1;
      end else if (group_op_q.size() == 0) begin
         req_valid <= 1'b0;
      end else if (group_op_q[0].drain_first && member_result_q.size() != 0) begin
         req_valid <= 1'b0;
      end else if ($urandom_range(99) < send_idle_pct[group_op_q[0].phase]) begin
         req_valid <= 1'b0;
      end else begin
         req_valid      <= 1'b1;
         req_func       <= group_op_q[0].func;
         req_group_addr <= group_op_q[0].group_addr;
         req_iface      <= group_op_q[0].iface;
      end
   end

   // Result side back-pressure.
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < rsp_idle_pct[rsp_phase]);
   end

   // Monitor: checks each result, then predicts the one for a newly accepted transaction.
   always @(posedge clock) begin
      member_result_type exp_res;
      group_op_type      op;
      req_accepted = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (member_result_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORT) begin
                  $display("%0t: unexpected result: hit %0b mask %h full %0b",
                           $realtime, rsp_hit, rsp_member_mask, rsp_table_full);
               end
            end else begin
               exp_res = member_result_q.pop_front();
               if (rsp_hit !== exp_res.hit || rsp_member_mask !== exp_res.member_mask ||
                   rsp_table_full !== exp_res.table_full) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORT) begin
                     $display("%0t: expected hit %0b mask %h full %0b, got %0b %h %0b",
                              $realtime, exp_res.hit, exp_res.member_mask, exp_res.table_full,
                              rsp_hit, rsp_member_mask, rsp_table_full);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            req_accepted = 1'b1;
            op = group_op_q.pop_front();
            rsp_phase = op.phase;
            exp_res = apply_group_op(op);
            member_result_q.push_back(exp_res);
            case (op.func)
               OP_JOIN:  join_count++;
               OP_LEAVE: leave_count++;
               default:  lookup_count++;
            endcase
            if (exp_res.hit) begin
               hit_count++;
            end
            if (exp_res.table_full) begin
               full_count++;
            end
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      logic [mgmt_pkg::ADDR_W-1:0]  addr_pool [POOL_SIZE];
      logic [mgmt_pkg::ADDR_W-1:0]  addr;
      logic [mgmt_pkg::IFACE_W-1:0] iface;
      func_code_type func;
      segment_type   seg_kind;
      int unsigned   seg_left;
      int unsigned   pick;
      int unsigned   phase;
      int            k;

      for (k = 0; k < TBL_ROWS; k++) begin
         grp_valid[k] = 1'b0;
      end

      // Directed: empty table, extreme addresses and interfaces, repeat joins,
      // leaves of non-members and unknown groups, row freeing and reuse, spare code.
      add_op(OP_LOOKUP, 32'h0000_0000, 5'd0,  0, 1'b0);
      add_op(OP_LEAVE,  32'hFFFF_FFFF, 5'd31, 0, 1'b0);
      add_op(OP_JOIN,   32'h0000_0000, 5'd0,  0, 1'b0);
      add_op(OP_JOIN,   32'h0000_0000, 5'd31, 0, 1'b0);
      add_op(OP_JOIN,   32'h0000_0000, 5'd0,  0, 1'b0);
      add_op(OP_LOOKUP, 32'h0000_0000, 5'd17, 0, 1'b0);
      add_op(OP_SPARE,  32'h0000_0000, 5'd31, 0, 1'b0);
      add_op(OP_JOIN,   32'hFFFF_FFFF, 5'd31, 0, 1'b0);
      add_op(OP_JOIN,   32'hE000_0001, 5'd5,  0, 1'b0);
      add_op(OP_LEAVE,  32'h0000_0000, 5'd7,  0, 1'b0);
      add_op(OP_LEAVE,  32'h0000_0000, 5'd0,  0, 1'b0);
      add_op(OP_LEAVE,  32'h0000_0000, 5'd31, 0, 1'b0);
      add_op(OP_LOOKUP, 32'h0000_0000, 5'd0,  0, 1'b0);
      add_op(OP_JOIN,   32'hAAAA_AAAA, 5'd10, 0, 1'b0);
      add_op(OP_JOIN,   32'h5555_5555, 5'd21, 0, 1'b0);
      add_op(OP_LEAVE,  32'hFFFF_FFFF, 5'd31, 0, 1'b0);
      add_op(OP_JOIN,   32'h1234_5678, 5'd16, 0, 1'b0);
      add_op(OP_LOOKUP, 32'hFFFF_FFFF, 5'd0,  0, 1'b0);
      add_op(OP_LEAVE,  32'h5555_5555, 5'd0,  0, 1'b0);
      add_op(OP_SPARE,  32'h5555_5555, 5'd31, 0, 1'b0);
      add_op(OP_LOOKUP, 32'hAAAA_AAAA, 5'd10, 0, 1'b0);

      // Address pool with extremes and near neighbors so the compare sees one-bit differences.
      addr_pool[0] = 32'h0000_0000;
      addr_pool[1] = 32'hFFFF_FFFF;
      for (k = 2; k < POOL_SIZE; k++) begin
         if (k % 4 == 0) begin
            addr_pool[k] = addr_pool[k-1] ^ (32'h1 << $urandom_range(31));
         end else begin
            addr_pool[k] = $urandom;
         end
      end

      // Random: segments that mostly join to fill the table, mostly leave to drain it, or mix.
      seg_left = 0;
      seg_kind = SEG_MIX;
      for (k = 0; k < RAND_ITEMS; k++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(40, 120);
            case ($urandom_range(2))
               0:       seg_kind = SEG_FILL;
               1:       seg_kind = SEG_DRAIN;
               default: seg_kind = SEG_MIX;
            endcase
         end
         seg_left--;
         pick = $urandom_range(99);
         case (seg_kind)
            SEG_FILL:  func = pick < 70 ? OP_JOIN : pick < 80 ? OP_LEAVE :
                              pick < 95 ? OP_LOOKUP : OP_SPARE;
            SEG_DRAIN: func = pick < 10 ? OP_JOIN : pick < 80 ? OP_LEAVE :
                              pick < 95 ? OP_LOOKUP : OP_SPARE;
            default:   func = pick < 33 ? OP_JOIN : pick < 66 ? OP_LEAVE :
                              pick < 95 ? OP_LOOKUP : OP_SPARE;
         endcase
         addr  = ($urandom_range(99) < 90) ? addr_pool[$urandom_range(POOL_SIZE-1)] : $urandom;
         iface = ($urandom_range(99) < 80) ? mgmt_pkg::IFACE_W'($urandom_range(3))
                                            : mgmt_pkg::IFACE_W'($urandom_range(31));
         phase = (k < RAND_ITEMS / 3) ? 0 : (k < 2 * RAND_ITEMS / 3) ? 1 : 2;
         add_op(func, addr, iface, phase,
                k == 0 || k == RAND_ITEMS / 3 || k == 2 * RAND_ITEMS / 3);
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (group_op_q.size() != 0 || member_result_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      mismatch_count += member_result_q.size();

      $display("Ran %0d joins, %0d leaves and %0d lookups; %0d results checked.",
               join_count, leave_count, lookup_count, result_count);
      $display("Group hits %0d, rows freed by leaves %0d, joins dropped on a full table %0d.",
               hit_count, row_freed_count, full_count);
      if (mismatch_count == 0) begin
         $display("multicast_group_member_table_unit test passed");
      end else begin
         $display("multicast_group_member_table_unit test failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2_000_000ns;
      $display("multicast_group_member_table_unit test failed");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/mgmt_pkg.sv
sv/mgmt_ctrl.sv
sv/mgmt_datapath.sv
sv/multicast_group_member_table_unit.sv
verif/tb_top.sv
